>>> sv/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package blr_pkg;

  localparam int REG_W     = 13;   // frame size register width
  localparam int ADDR_W    = 24;   // framebuffer address width
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic active;
    logic at_end;
  } walk_status_t;

endpackage

>>> sv/blr_walker.sv
// Line state: endpoint load, error term and one Bresenham step per item.
module blr_walker import blr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  step,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COLOR_W-1:0]    color,
  output logic [COORD_BITS-1:0] cur_x,
  output logic [COORD_BITS-1:0] cur_y,
  output logic [COLOR_W-1:0]    cur_color,
  output walk_status_t          status
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic [CW-1:0]        cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [CW-1:0]        cur_x_nxt, cur_y_nxt;
  logic                 neg_x_r, neg_y_r;
  logic [CW-1:0]        span_x_r;
  logic signed [CW:0]   span_y_neg_r;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [COLOR_W-1:0]   color_r;
  logic                 active_r;

  logic signed [CW:0]   dx, dy, adx, ady;
  logic signed [EW-1:0] err_load;
  logic signed [EW:0]   dbl, sx_ext, sy_ext;
  logic                 move_x, move_y, at_end;

  // load-time setup
  always_comb begin
    dx  = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    dy  = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    adx = dx[CW] ? -dx : dx;
    ady = dy[CW] ? -dy : dy;
    err_load = $signed(EW'(adx)) - $signed(EW'(ady));
  end

  assign at_end = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

  // step: doubled error against both spans
  always_comb begin
    dbl    = {err_r, 1'b0};
    sx_ext = $signed({{(EW+1-CW){1'b0}}, span_x_r});
    sy_ext = $signed({{(EW-CW){span_y_neg_r[CW]}}, span_y_neg_r});
    move_x = dbl >= sy_ext;
    move_y = dbl <= sx_ext;
    err_nxt = err_r;
    if (move_x) err_nxt = err_nxt + $signed(sy_ext[EW-1:0]);
    if (move_y) err_nxt = err_nxt + $signed(sx_ext[EW-1:0]);
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (move_x) cur_x_nxt = neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    if (move_y) cur_y_nxt = neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (step && active_r && at_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x_r      <= start_x;
      cur_y_r      <= start_y;
      tgt_x_r      <= end_x;
      tgt_y_r      <= end_y;
      neg_x_r      <= !($signed(start_x) < $signed(end_x));
      neg_y_r      <= !($signed(start_y) < $signed(end_y));
      span_x_r     <= adx[CW-1:0];
      span_y_neg_r <= -ady;
      err_r        <= err_load;
      color_r      <= color;
    end else if (step && active_r && !at_end) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  assign cur_x          = cur_x_r;
  assign cur_y          = cur_y_r;
  assign cur_color      = color_r;
  assign status.active  = active_r;
  assign status.at_end  = at_end;

endmodule

>>> sv/blr_emit.sv
// Result stage: frame clipping, address computation and the output register.
module blr_emit import blr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  emit,
  input  logic                  out_stall,
  input  logic [COORD_BITS-1:0] cur_x,
  input  logic [COORD_BITS-1:0] cur_y,
  input  logic [COLOR_W-1:0]    cur_color,
  input  logic                  at_end,
  input  logic [REG_W-1:0]      frame_width,
  input  logic [REG_W-1:0]      frame_height,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic                  out_write_enable,
  output logic [COLOR_W-1:0]    out_pixel_color,
  output logic                  out_last
);

  localparam int UW = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

  logic [UW-1:0]        x_u, y_u, w_u, h_u;
  logic                 in_frame;
  logic [2*REG_W-1:0]   prod, sum;
  logic [ADDR_W-1:0]    addr;

  logic                  valid_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  we_r, last_r;
  logic [COLOR_W-1:0]    color_r;

  always_comb begin
    x_u = UW'(cur_x);
    y_u = UW'(cur_y);
    w_u = UW'(frame_width);
    h_u = UW'(frame_height);
    in_frame = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] && (x_u < w_u) && (y_u < h_u);
    // inside the frame both coordinates are below 2^REG_W
    prod = (2*REG_W)'(y_u[REG_W-1:0]) * (2*REG_W)'(frame_width);
    sum  = prod + (2*REG_W)'(x_u[REG_W-1:0]);
    addr = in_frame ? sum[ADDR_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      x_r     <= cur_x;
      y_r     <= cur_y;
      addr_r  <= addr;
      we_r    <= in_frame;
      color_r <= cur_color;
      last_r  <= at_end;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_x       = x_r;
  assign out_pixel_y       = y_r;
  assign out_pixel_address = addr_r;
  assign out_write_enable  = we_r;
  assign out_pixel_color   = color_r;
  assign out_last          = last_r;

  a_addr_zero_off_frame: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !we_r |-> addr_r == '0)
    else $error("address not zero for pixel outside the frame");

endmodule

>>> sv/bresenham_line_rasterizer_top.sv
// Top level of the all-octant Bresenham line rasterizer with frame clipping.
//
// Input channel (in_valid/in_stall): a load item (in_kind 0) latches the
// endpoints and colour and gives no result; a step item (in_kind 1) gives
// the current pixel of the active line and advances it. A step with no
// active line is consumed with no result; a load drops any line in flight.
// Result channel (out_valid/out_stall): one pixel per step item, with
// coordinates, address y*width+x (0 when clipped), write enable, colour and
// a last flag on the endpoint. out_valid rises in the cycle after a step item
// is accepted. One item is accepted every cycle unless a step item meets a
// held result; the single output register sets that figure. While a result
// is held by out_stall, step items are stalled but load items are still taken.
// Config port (cfg_valid/cfg_ready): cfg_ready is always high; index 0 is
// frame width, index 1 frame height, other indices are ignored. Write only
// while idle.
// Reset (rst_n, synchronous): no active line, no result pending, frame
// size back to 640 x 480. No clearing pass is needed.
module bresenham_line_rasterizer_top import blr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_W-1:0]    in_line_color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic                  out_write_enable,
  output logic [COLOR_W-1:0]    out_pixel_color,
  output logic                  out_last
);

  logic [REG_W-1:0]      frame_width_r, frame_height_r;
  logic                  in_fire, load, step, emit;
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [COLOR_W-1:0]    cur_color;
  walk_status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // only a step item needs the output register free
  assign in_stall = out_valid && out_stall && (in_kind == KIND_STEP);
  assign in_fire  = in_valid && !in_stall;
  assign load     = in_fire && (in_kind == KIND_LOAD);
  assign step     = in_fire && (in_kind == KIND_STEP);
  assign emit     = step && status.active;

  blr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .step      (step),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .color     (in_line_color),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cur_color (cur_color),
    .status    (status)
  );

  blr_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .out_stall         (out_stall),
    .cur_x             (cur_x),
    .cur_y             (cur_y),
    .cur_color         (cur_color),
    .at_end            (status.at_end),
    .frame_width       (frame_width_r),
    .frame_height      (frame_height_r),
    .out_valid         (out_valid),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_write_enable  (out_write_enable),
    .out_pixel_color   (out_pixel_color),
    .out_last          (out_last)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    load && !(out_valid && out_stall) |=> !out_valid)
    else $error("load item produced a pixel");

  a_endpoint_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit && status.at_end |=> !status.active || $past(load))
    else $error("line still active after endpoint pixel");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid && (out_last == $past(status.at_end)))
    else $error("emitted pixel missing or last flag wrong");

  a_step_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && !status.active && !(out_valid && out_stall) |=> !out_valid)
    else $error("step with no active line produced a pixel");

endmodule

>>> verif/tb_bresenham_line_rasterizer_top.sv
// Self-checking testbench for the Bresenham line rasterizer: directed table, then random lines.
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer_top;
  import blr_pkg::*;

  localparam int CW        = 16;
  localparam int N_PHASES  = 7;
  localparam int PHASE_LEN = 146;
  localparam int IDLE_MAX  = 200;  // cycles with no accepted item before giving up
  localparam int SETTLE    = 4;    // cycles before a register write or the end
  localparam int MAX_PRINT = 40;

  // indexes past the register list; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
    logic [ADDR_W-1:0]  addr;
    logic               we;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic               kind;
    logic [CW-1:0]      sx;
    logic [CW-1:0]      sy;
    logic [CW-1:0]      ex;
    logic [CW-1:0]      ey;
    logic [COLOR_W-1:0] color;
    logic               typed;
    pixel_t             want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = KIND_LOAD;
  logic [CW-1:0]        in_start_x = '0;
  logic [CW-1:0]        in_start_y = '0;
  logic [CW-1:0]        in_end_x = '0;
  logic [CW-1:0]        in_end_y = '0;
  logic [COLOR_W-1:0]   in_line_color = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CW-1:0]        out_pixel_x;
  logic [CW-1:0]        out_pixel_y;
  logic [ADDR_W-1:0]    out_pixel_address;
  logic                 out_write_enable;
  logic [COLOR_W-1:0]   out_pixel_color;
  logic                 out_last;

  bresenham_line_rasterizer_top #(.COORD_BITS(CW)) DUT (.*);

  always #5 clk = ~clk;

  // rasterizer state as seen by the predictor
  int                 frame_w, frame_h;
  int                 cur_x, cur_y, tgt_x, tgt_y;
  int                 span_x, span_yn, err;
  bit                 neg_x, neg_y, walking;
  logic [COLOR_W-1:0] held_color;

  pixel_t pixel_q[$];
  stim_row_t dir_tab[$];

  int  mismatches = 0;
  int  items_counted = 0, loads_sent = 0, pixels_checked = 0;
  int  we_seen = 0, ends_seen = 0, frames_used = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1, stalls_on = 1'b1, quiet = 1'b0;

  int phase_w[N_PHASES] = '{1, 4096, 0, 8191, 33, 8191, 640};
  int phase_h[N_PHASES] = '{1, 4096, 0, 8191, 17, 5, 480};

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINT)
      $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  // one input item through the predictor: loads latch the line, steps on an active line emit a pixel
  task automatic raster_step(input logic k, input logic signed [CW-1:0] sx, sy, ex, ey,
                             input logic [COLOR_W-1:0] col, output bit got, output pixel_t px);
    int     dx, dy, dbl;
    bit     in_frame;
    longint lin;
    got = 1'b0;
    px = '0;
    if (k == KIND_LOAD) begin
      cur_x = sx;
      cur_y = sy;
      tgt_x = ex;
      tgt_y = ey;
      dx = tgt_x - cur_x;
      dy = tgt_y - cur_y;
      span_x = (dx < 0) ? -dx : dx;
      span_yn = (dy < 0) ? dy : -dy;
      neg_x = !(cur_x < tgt_x);
      neg_y = !(cur_y < tgt_y);
      err = span_x + span_yn;
      held_color = col;
      walking = 1'b1;
    end else if (walking) begin
      in_frame = cur_x >= 0 && cur_x < frame_w && cur_y >= 0 && cur_y < frame_h;
      lin = longint'(cur_y) * frame_w + cur_x;
      got = 1'b1;
      px.x = cur_x[CW-1:0];
      px.y = cur_y[CW-1:0];
      px.addr = in_frame ? lin[ADDR_W-1:0] : '0;
      px.we = in_frame;
      px.color = held_color;
      px.last = (cur_x == tgt_x) && (cur_y == tgt_y);
      if (px.last) begin
        walking = 1'b0;
      end else begin
        dbl = 2 * err;
        if (dbl >= span_yn) begin
          err += span_yn;
          cur_x += neg_x ? -1 : 1;
        end
        if (dbl <= span_x) begin
          err += span_x;
          cur_y += neg_y ? -1 : 1;
        end
      end
    end
  endtask

  task automatic send_item(input logic k, input logic [CW-1:0] sx, sy, ex, ey,
                           input logic [COLOR_W-1:0] col, input logic typed = 1'b0,
                           input pixel_t typed_px = '0);
    bit     got;
    pixel_t px;
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_line_color <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    raster_step(k, sx, sy, ex, ey, col, got, px);
    if (got) pixel_q.push_back(typed ? typed_px : px);
    if (k == KIND_LOAD) loads_sent++;
    items_counted++;
  endtask

  task automatic load_item(input int x0, y0, x1, y1);
    send_item(KIND_LOAD, x0[CW-1:0], y0[CW-1:0], x1[CW-1:0], y1[CW-1:0], $urandom);
  endtask

  // endpoint payload on a step is junk and must be ignored
  task automatic step_item();
    send_item(KIND_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
              $urandom);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAME_WIDTH) frame_w = val;
    else if (idx == CFG_FRAME_HEIGHT) frame_h = val;
  endtask

  task automatic set_frame(input int w, h);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write(CFG_FRAME_WIDTH, w[REG_W-1:0]);
    cfg_write(CFG_FRAME_HEIGHT, h[REG_W-1:0]);
    cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, REG_W'($urandom));
    cfg_valid <= 1'b0;
    frames_used++;
  endtask

  // coordinate inside the frame, near one of its edges, or loosely around it
  function automatic int near_edge(input int dim);
    case ($urandom_range(0, 3))
      0: return (dim == 0) ? 0 : int'($urandom_range(0, dim - 1));
      1: return int'($urandom_range(0, 8)) - 4;
      2: return dim + int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, dim + 128)) - 64;
    endcase
  endfunction

  // short line, usually walked to its end and a little past, sometimes cut off
  task automatic walk_random_line();
    int x0, y0, x1, y1, ax, ay, len, n;
    x0 = near_edge(frame_w);
    y0 = near_edge(frame_h);
    x1 = x0 + int'($urandom_range(0, 24)) - 12;
    y1 = y0 + int'($urandom_range(0, 24)) - 12;
    ax = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay = (y1 > y0) ? y1 - y0 : y0 - y1;
    len = ((ax > ay) ? ax : ay) + 1;
    load_item(x0, y0, x1, y1);
    if ($urandom_range(0, 4) != 0) n = len + int'($urandom_range(0, 2));
    else n = $urandom_range(0, len - 1);
    repeat (n) step_item();
  endtask

  task automatic play_phase(input int target);
    int stop_at;
    stop_at = items_counted + target;
    while (items_counted < stop_at) begin
      if ($urandom_range(0, 11) == 0) gaps_on = !gaps_on;
      if ($urandom_range(0, 11) == 0) stalls_on = !stalls_on;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: walk_random_line();
        7: begin
          // full-range endpoints: long line, abandoned after a few pixels
          load_item($urandom, $urandom, $urandom, $urandom);
          repeat ($urandom_range(1, 8)) step_item();
        end
        8: step_item();
        default: begin
          load_item(near_edge(frame_w), near_edge(frame_h), $urandom, $urandom);
          walk_random_line();
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet || !stalls_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      pixels_checked++;
      if (out_write_enable) we_seen++;
      if (out_last) ends_seen++;
      if (pixel_q.size() == 0) begin
        flag_mismatch("unexpected pixel x", out_pixel_x, 0);
      end else begin
        e = pixel_q.pop_front();
        if (out_pixel_x !== e.x) flag_mismatch("pixel_x", out_pixel_x, e.x);
        if (out_pixel_y !== e.y) flag_mismatch("pixel_y", out_pixel_y, e.y);
        if (out_pixel_address !== e.addr)
          flag_mismatch("pixel_address", out_pixel_address, e.addr);
        if (out_write_enable !== e.we)
          flag_mismatch("write_enable", out_write_enable, e.we);
        if (out_pixel_color !== e.color)
          flag_mismatch("pixel_color", out_pixel_color, e.color);
        if (out_last !== e.last) flag_mismatch("last", out_last, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int waited;
    frame_w = FRAME_WIDTH_RST;
    frame_h = FRAME_HEIGHT_RST;
    cur_x = 0;
    cur_y = 0;
    tgt_x = 0;
    tgt_y = 0;
    span_x = 0;
    span_yn = 0;
    err = 0;
    neg_x = 1'b0;
    neg_y = 1'b0;
    walking = 1'b0;
    held_color = '0;

    // kind, sx, sy, ex, ey, color, typed, {x, y, addr, we, color, last}
    dir_tab = '{
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},  // no line yet
      '{KIND_LOAD, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'd0, 16'd0, 24'd0, 1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},  // past the endpoint
      '{KIND_LOAD, 16'd639, 16'd479, 16'd639, 16'd479, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'd639, 16'd479, 24'd307199, 1'b1, 32'h0, 1'b1}},
      '{KIND_LOAD, 16'd640, 16'd479, 16'd640, 16'd479, 32'hA5A5_A5A5, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'd640, 16'd479, 24'd0, 1'b0, 32'hA5A5_A5A5, 1'b1}},
      '{KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h5A5A_5A5A, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'hFFFF, 16'hFFFF, 24'd0, 1'b0, 32'h5A5A_5A5A, 1'b1}},
      '{KIND_LOAD, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h1234_5678, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'h8000, 16'h7FFF, 24'd0, 1'b0, 32'h1234_5678, 1'b0}},
      '{KIND_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
      // reload mid-line: the long line above is dropped
      '{KIND_LOAD, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'h8765_4321, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b1,
        '{16'h7FFF, 16'h8000, 24'd0, 1'b0, 32'h8765_4321, 1'b0}},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_LOAD, 16'd10, 16'd10, 16'd14, 16'd12, 32'h0000_FFFF, 1'b0, '0},  // shallow
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_LOAD, 16'd20, 16'd5, 16'd19, 16'd8, 32'hFFFF_0000, 1'b0, '0},  // steep, -x
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0},
      '{KIND_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].kind, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey,
                dir_tab[i].color, dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      quiet = (p == N_PHASES - 1);  // no gaps or stalls in the closing phase
      set_frame(phase_w[p], phase_h[p]);
      play_phase(PHASE_LEN);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pixel_q.size() != 0 && waited < IDLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pixel_q.size() != 0) flag_mismatch("pixels never delivered", pixel_q.size(), 0);

    $display("run: %0d items (%0d line loads) over %0d frame sizes incl. zero and 8191",
             items_counted, loads_sent, frames_used);
    $display("run: %0d pixels checked, %0d inside the frame, %0d line endpoints, %0d errors",
             pixels_checked, we_seen, ends_seen, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
